[hdl/wsstat_pkg.sv]
// Shared types and constants for the windowed signal-strength statistics block.
// No dependencies; used by wsstat_ctrl, wsstat_dp and windowed_signal_strength_stats.
`timescale 1ns / 1ps

package wsstat_pkg;

  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned FIELD_W         = 16;
  localparam int unsigned SUM_W           = 32;
  localparam int unsigned COUNT_W         = 16;
  localparam int unsigned DIV_STEPS       = 16;
  localparam int unsigned STEP_W          = $clog2(DIV_STEPS);

  localparam logic [FIELD_W-1:0] WINDOW_RESET = 16'd24000;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic take;      // accept the sample on the input port
    logic div_step;  // advance the divider by one quotient bit
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic closes;    // the next sample ends the window
    logic div_last;  // the divider is on its final step
  } status_t;

endpackage

[hdl/wsstat_ctrl.sv]
// Controller state machine: input/output handshakes and divider sequencing.
// Depends on wsstat_pkg.
`timescale 1ns / 1ps

module wsstat_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  wsstat_pkg::status_t status,
  output wsstat_pkg::cmd_t  cmd
);
  import wsstat_pkg::*;

  state_t state;
  state_t state_next;

  // A sample that does not end the window may always enter.
  assign in_ready  = (state == S_IDLE) || !status.closes;
  assign out_valid = (state == S_OUT);

  always_comb begin
    cmd.take     = in_valid && in_ready;
    cmd.div_step = (state == S_DIV);
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid && status.closes) state_next = S_DIV;
      end
      S_DIV: begin
        if (status.div_last) state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[hdl/wsstat_dp.sv]
// Datapath: window accumulators, window length register, serial divider, result registers.
// Depends on wsstat_pkg.
`timescale 1ns / 1ps

module wsstat_dp #(
  parameter int unsigned SAMPLE_BITS = wsstat_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [wsstat_pkg::FIELD_W-1:0]   cfg_wr_data,
  input  logic [wsstat_pkg::FIELD_W-1:0]   sample,
  input  wsstat_pkg::cmd_t                 cmd,
  output wsstat_pkg::status_t              status,
  output logic [wsstat_pkg::FIELD_W-1:0]   highest,
  output logic [wsstat_pkg::FIELD_W-1:0]   lowest,
  output logic [wsstat_pkg::FIELD_W-1:0]   average
);
  import wsstat_pkg::*;

  localparam logic [SAMPLE_BITS-1:0] LOW_INIT = {SAMPLE_BITS{1'b1}};

  logic [FIELD_W-1:0]     window_length;
  logic [COUNT_W-1:0]     sample_count;
  logic [SUM_W-1:0]       running_sum;
  logic [SAMPLE_BITS-1:0] running_low;
  logic [SAMPLE_BITS-1:0] running_high;

  logic [SAMPLE_BITS-1:0] s;
  logic [COUNT_W:0]       count_inc;
  logic [SUM_W-1:0]       sum_next;
  logic [SAMPLE_BITS-1:0] low_next;
  logic [SAMPLE_BITS-1:0] high_next;
  logic [COUNT_W-1:0]     divisor_next;

  // Divider: partial remainder, quotient/dividend shift word, divisor, step count
  logic [FIELD_W-1:0]     rem;
  logic [FIELD_W-1:0]     quot;
  logic [COUNT_W-1:0]     divisor;
  logic [STEP_W-1:0]      step_cnt;
  logic [FIELD_W:0]       trial;
  logic [FIELD_W:0]       diff;
  logic [SAMPLE_BITS-1:0] out_high;
  logic [SAMPLE_BITS-1:0] out_low;

  assign s            = sample[SAMPLE_BITS-1:0];
  assign count_inc    = {1'b0, sample_count} + {{COUNT_W{1'b0}}, 1'b1};
  assign sum_next     = running_sum + {{(SUM_W-SAMPLE_BITS){1'b0}}, s};
  assign low_next     = (s < running_low)  ? s : running_low;
  assign high_next    = (s > running_high) ? s : running_high;
  assign divisor_next = (count_inc[COUNT_W-1:0] == '0) ? {{(COUNT_W-1){1'b0}}, 1'b1}
                                                       : count_inc[COUNT_W-1:0];

  always_comb begin
    status.closes   = (count_inc >= {1'b0, window_length});
    status.div_last = (step_cnt == STEP_W'(DIV_STEPS - 1));
  end

  assign trial = {rem, quot[FIELD_W-1]};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WINDOW_RESET;
      sample_count  <= '0;
      running_sum   <= '0;
      running_low   <= LOW_INIT;
      running_high  <= '0;
      step_cnt      <= '0;
    end else begin
      if (cfg_wr_en) window_length <= cfg_wr_data;
      if (cmd.take) begin
        if (status.closes) begin
          // Start a new window; the totals move to the divider.
          sample_count <= '0;
          running_sum  <= '0;
          running_low  <= LOW_INIT;
          running_high <= '0;
          step_cnt     <= '0;
        end else begin
          sample_count <= count_inc[COUNT_W-1:0];
          running_sum  <= sum_next;
          running_low  <= low_next;
          running_high <= high_next;
        end
      end
      if (cmd.div_step) step_cnt <= step_cnt + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && status.closes) begin
      // High half of the sum stays below the count, so the quotient fits 16 bits.
      rem      <= sum_next[SUM_W-1:FIELD_W];
      quot     <= sum_next[FIELD_W-1:0];
      divisor  <= divisor_next;
      out_high <= high_next;
      out_low  <= low_next;
    end else if (cmd.div_step) begin
      if (!diff[FIELD_W]) begin
        rem  <= diff[FIELD_W-1:0];
        quot <= {quot[FIELD_W-2:0], 1'b1};
      end else begin
        rem  <= trial[FIELD_W-1:0];
        quot <= {quot[FIELD_W-2:0], 1'b0};
      end
    end
  end

  assign highest = FIELD_W'(out_high);
  assign lowest  = FIELD_W'(out_low);
  assign average = quot;

endmodule

[hdl/windowed_signal_strength_stats.sv]
// Top level of the windowed signal-strength statistics block.
// Depends on wsstat_pkg, wsstat_ctrl and wsstat_dp.
//
//   port group     direction  handshake            payload
//   sample in      in         in_valid/in_ready    sample
//   stats out      out        out_valid/out_ready  highest, lowest, average
//   config write   in         cfg_wr_en            cfg_wr_data (window length)
//
// Samples enter one per cycle while in_ready is high. The sample that ends a window
// hands its totals to a bit-serial divider, then the result waits in its register
// until taken. Meanwhile the next window keeps filling; only a sample that would end
// that window stalls until the previous result has gone out.
// Reset is synchronous; the window length returns to 24000 and the window empties.
`timescale 1ns / 1ps

module windowed_signal_strength_stats #(
  parameter int unsigned SAMPLE_BITS = wsstat_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [wsstat_pkg::FIELD_W-1:0] cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [wsstat_pkg::FIELD_W-1:0] sample,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [wsstat_pkg::FIELD_W-1:0] highest,
  output logic [wsstat_pkg::FIELD_W-1:0] lowest,
  output logic [wsstat_pkg::FIELD_W-1:0] average
);
  import wsstat_pkg::*;

  cmd_t    cmd;
  status_t status;

  wsstat_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  wsstat_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .sample      (sample),
    .cmd         (cmd),
    .status      (status),
    .highest     (highest),
    .lowest      (lowest),
    .average     (average)
  );

endmodule
